// File: rtl/core/espd_pkg.sv
// ----------------------------------------------------------------------------
// espd_pkg
// Shared constants and types of the escape-shift PCM chunk decoder.
// ----------------------------------------------------------------------------
package espd_pkg;

    localparam int unsigned SAMPLES_PER_CHUNK = 2048;
    localparam int unsigned SCNT_W            = $clog2(SAMPLES_PER_CHUNK);

    localparam logic [7:0]  ESCAPE_BYTE = 8'h80;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [15:0] sample;
        logic               channel;
        logic               last_in_chunk;
        logic               chunk_error;
    } result_t;

endpackage

// File: rtl/core/espd_decode.sv
// ----------------------------------------------------------------------------
// espd_decode
// Chunk parser: length, shift byte, plain and escaped samples, surplus skip.
// Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module espd_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    output logic              res_valid,
    output espd_pkg::result_t res
);
    import espd_pkg::*;

    typedef enum logic [2:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SHIFT,
        PH_SAMPLE,
        PH_ESC_HI,
        PH_ESC_LO,
        PH_SKIP
    } phase_t;

    localparam logic [SCNT_W-1:0] SCNT_LAST = SCNT_W'(SAMPLES_PER_CHUNK - 1);

    phase_t              phase_reg, phase_next;
    logic [15:0]         bytes_left_reg, bytes_left_next;
    logic [3:0]          shift_even_reg, shift_even_next;
    logic [3:0]          shift_odd_reg, shift_odd_next;
    logic [SCNT_W-1:0]   samples_done_reg, samples_done_next;
    logic [7:0]          escape_high_reg, escape_high_next;

    logic [15:0]         bytes_dec;
    logic                chunk_end;
    logic [3:0]          shift_sel;
    logic [15:0]         ext;
    logic [15:0]         plain_value;
    logic                sample_go;
    logic [15:0]         sample_value;
    logic                error_go;
    logic                last_sample;

    always_comb
    begin
        bytes_dec   = bytes_left_reg - 16'd1;
        chunk_end   = (bytes_dec == 16'd0);
        shift_sel   = samples_done_reg[0] ? shift_odd_reg : shift_even_reg;
        ext         = {{8{data_byte[7]}}, data_byte};
        plain_value = ext << shift_sel;
        last_sample = (samples_done_reg == SCNT_LAST);

        phase_next        = phase_reg;
        bytes_left_next   = bytes_dec;
        shift_even_next   = shift_even_reg;
        shift_odd_next    = shift_odd_reg;
        samples_done_next = samples_done_reg;
        escape_high_next  = escape_high_reg;
        sample_go         = 1'b0;
        sample_value      = plain_value;
        error_go          = 1'b0;

        case (phase_reg)
            PH_LEN_HI:
            begin
                bytes_left_next = {data_byte, 8'h00};
                phase_next      = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                bytes_left_next = {bytes_left_reg[15:8], data_byte};
                if ({bytes_left_reg[15:8], data_byte} == 16'd0)
                    error_go = 1'b1;
                else
                    phase_next = PH_SHIFT;
            end
            PH_SHIFT:
            begin
                shift_even_next   = data_byte[7:4];
                shift_odd_next    = data_byte[3:0];
                samples_done_next = '0;
                if (chunk_end)
                    error_go = 1'b1;
                else
                    phase_next = PH_SAMPLE;
            end
            PH_SAMPLE:
            begin
                if (data_byte == ESCAPE_BYTE)
                begin
                    if (chunk_end)
                        error_go = 1'b1;
                    else
                        phase_next = PH_ESC_HI;
                end
                else
                    sample_go = 1'b1;
            end
            PH_ESC_HI:
            begin
                escape_high_next = data_byte;
                if (chunk_end)
                    error_go = 1'b1;
                else
                    phase_next = PH_ESC_LO;
            end
            PH_ESC_LO:
            begin
                sample_value = {escape_high_reg, data_byte};
                sample_go    = 1'b1;
            end
            PH_SKIP:
            begin
                if (chunk_end)
                    phase_next = PH_LEN_HI;
            end
            default:
            begin
                phase_next = PH_LEN_HI;
            end
        endcase

        // finish a sample: last of chunk, early end, or continue
        if (sample_go)
        begin
            if (last_sample)
            begin
                samples_done_next = '0;
                phase_next        = chunk_end ? PH_LEN_HI : PH_SKIP;
            end
            else if (chunk_end)
                error_go = 1'b1;
            else
            begin
                samples_done_next = samples_done_reg + 1'b1;
                phase_next        = PH_SAMPLE;
            end
        end

        if (error_go)
        begin
            samples_done_next = '0;
            phase_next        = PH_LEN_HI;
        end

        res_valid         = accept && (sample_go || error_go);
        res.sample        = error_go ? 16'sd0 : $signed(sample_value);
        res.channel       = error_go ? 1'b0 : samples_done_reg[0];
        res.last_in_chunk = error_go ? 1'b0 : last_sample;
        res.chunk_error   = error_go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEN_HI;
            bytes_left_reg   <= '0;
            shift_even_reg   <= '0;
            shift_odd_reg    <= '0;
            samples_done_reg <= '0;
            escape_high_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            shift_even_reg   <= shift_even_next;
            shift_odd_reg    <= shift_odd_next;
            samples_done_reg <= samples_done_next;
            escape_high_reg  <= escape_high_next;
        end
    end

endmodule

// File: rtl/core/espd_out_buf.sv
// ----------------------------------------------------------------------------
// espd_out_buf
// Two-entry result register with skid; holds results while the sink stalls.
// ----------------------------------------------------------------------------
module espd_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  espd_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output espd_pkg::result_t out_data
);
    import espd_pkg::*;

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    pop;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/core/escape_shift_pcm_decoder_core.sv
// ----------------------------------------------------------------------------
// escape_shift_pcm_decoder_core
// Escape-shift PCM chunk decoder: one payload byte in per beat, at most one
// decoded sample or chunk error out per byte.
// A result is registered in the result buffer with its byte and leaves behind any older results.
// Throughput: one byte per cycle while the result buffer is not full; the parser state updates in a single pass.
// Input stalls only when both entries of the result buffer are occupied.
// Reset (rst_n low, async): parser waits for a length high byte, buffer empty.
// ----------------------------------------------------------------------------
module escape_shift_pcm_decoder_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample,
    output logic               channel,
    output logic               last_in_chunk,
    output logic               chunk_error
);
    import espd_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    buf_full;
    result_t out_data;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    espd_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    espd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign sample        = out_data.sample;
    assign channel       = out_data.channel;
    assign last_in_chunk = out_data.last_in_chunk;
    assign chunk_error   = out_data.chunk_error;

endmodule

// File: bench/pcm_decode_checker.sv
// ----------------------------------------------------------------------------
// pcm_decode_checker
// Watches the byte and result channels of the escape-shift PCM decoder.
// Tracks the chunk parser for every accepted byte beat and queues the result
// it implies. Compares each accepted result beat, field by field, against the
// oldest queued result.
// ----------------------------------------------------------------------------
module pcm_decode_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] sample,
    input  logic               channel,
    input  logic               last_in_chunk,
    input  logic               chunk_error,
    output int                 fail_count,
    output int                 pending,
    output int                 byte_count,
    output int                 sample_count,
    output int                 error_count,
    output int                 chunk_end_count
);
    import espd_pkg::*;

    typedef enum logic [2:0] {
        LEN_HI,
        LEN_LO,
        SHIFT_BYTE,
        SAMPLE_BYTE,
        ESC_HI,
        ESC_LO,
        SKIP_TAIL
    } parse_phase_t;

    parse_phase_t phase;
    logic [15:0]  bytes_left;
    logic [3:0]   shift_even;
    logic [3:0]   shift_odd;
    int           samples_done;
    logic [7:0]   escape_high;
    result_t      expected_results[$];
    int           result_index;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH: %s", msg);
    endtask

    task automatic push_chunk_error();
        result_t r;
        r = '0;
        r.chunk_error = 1'b1;
        expected_results.push_back(r);
        samples_done = 0;
        phase = LEN_HI;
    endtask

    task automatic push_sample(input logic [15:0] value, input logic chunk_end);
        result_t r;
        r = '0;
        r.sample = value;
        r.channel = samples_done[0];
        samples_done++;
        if (samples_done >= SAMPLES_PER_CHUNK) begin
            r.last_in_chunk = 1'b1;
            samples_done = 0;
            phase = chunk_end ? LEN_HI : SKIP_TAIL;
            expected_results.push_back(r);
        end
        else if (chunk_end) begin
            push_chunk_error();
        end
        else begin
            phase = SAMPLE_BYTE;
            expected_results.push_back(r);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic        chunk_end;
        logic [15:0] widened;
        logic [3:0]  sh;
        case (phase)
            LEN_HI:
            begin
                bytes_left = {b, 8'h00};
                phase = LEN_LO;
            end
            LEN_LO:
            begin
                bytes_left[7:0] = b;
                if (bytes_left == 16'd0)
                    push_chunk_error();
                else
                    phase = SHIFT_BYTE;
            end
            default:
            begin
                bytes_left = bytes_left - 16'd1;
                chunk_end = (bytes_left == 16'd0);
                case (phase)
                    SHIFT_BYTE:
                    begin
                        shift_even = b[7:4];
                        shift_odd = b[3:0];
                        samples_done = 0;
                        if (chunk_end)
                            push_chunk_error();
                        else
                            phase = SAMPLE_BYTE;
                    end
                    SAMPLE_BYTE:
                    begin
                        if (b == ESCAPE_BYTE) begin
                            if (chunk_end)
                                push_chunk_error();
                            else
                                phase = ESC_HI;
                        end
                        else begin
                            sh = samples_done[0] ? shift_odd : shift_even;
                            widened = {{8{b[7]}}, b};
                            push_sample(widened << sh, chunk_end);
                        end
                    end
                    ESC_HI:
                    begin
                        escape_high = b;
                        if (chunk_end)
                            push_chunk_error();
                        else
                            phase = ESC_LO;
                    end
                    ESC_LO:
                        push_sample({escape_high, b}, chunk_end);
                    SKIP_TAIL:
                        if (chunk_end)
                            phase = LEN_HI;
                    default:
                        phase = LEN_HI;
                endcase
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            phase = LEN_HI;
            bytes_left = '0;
            shift_even = '0;
            shift_odd = '0;
            samples_done = 0;
            escape_high = '0;
            expected_results.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                result_index++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                        result_index));
                end
                else begin
                    want = expected_results.pop_front();
                    if (sample !== want.sample)
                        report_mismatch($sformatf("result %0d sample %0d, want %0d",
                            result_index, sample, want.sample));
                    if (channel !== want.channel)
                        report_mismatch($sformatf("result %0d channel %0b, want %0b",
                            result_index, channel, want.channel));
                    if (last_in_chunk !== want.last_in_chunk)
                        report_mismatch($sformatf("result %0d last_in_chunk %0b, want %0b",
                            result_index, last_in_chunk, want.last_in_chunk));
                    if (chunk_error !== want.chunk_error)
                        report_mismatch($sformatf("result %0d chunk_error %0b, want %0b",
                            result_index, chunk_error, want.chunk_error));
                    if (want.chunk_error)
                        error_count++;
                    else
                        sample_count++;
                    if (want.last_in_chunk)
                        chunk_end_count++;
                end
            end
            if (in_valid && !in_stall) begin
                byte_count++;
                decode_byte(data_byte);
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: bench/escape_shift_pcm_decoder_core_test.sv
// ----------------------------------------------------------------------------
// escape_shift_pcm_decoder_core_test
// Drives the decoder with about six hundred bytes of directed and random
// chunks: zero length, chunks cut at every parse point, plain and escaped
// samples under all shifts. Random idle and stall bursts on both channels;
// a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module escape_shift_pcm_decoder_core_test;
    import espd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PAYLOAD_MIN  = 580;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] sample;
    logic               channel;
    logic               last_in_chunk;
    logic               chunk_error;

    int         fail_count;
    int         pending;
    int         byte_count;
    int         sample_count;
    int         error_count;
    int         chunk_end_count;
    int         gap_mode;
    int         stall_mode;
    int         cycle_count;
    logic [7:0] payload[$];

    escape_shift_pcm_decoder_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .channel       (channel),
        .last_in_chunk (last_in_chunk),
        .chunk_error   (chunk_error)
    );

    pcm_decode_checker decode_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample          (sample),
        .channel         (channel),
        .last_in_chunk   (last_in_chunk),
        .chunk_error     (chunk_error),
        .fail_count      (fail_count),
        .pending         (pending),
        .byte_count      (byte_count),
        .sample_count    (sample_count),
        .error_count     (error_count),
        .chunk_end_count (chunk_end_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_mode != 0 && $urandom_range(0, stall_mode == 1 ? 7 : 1) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic queue_chunk(input int n_samples, input int esc_pct, input int surplus,
                               input int cut);
        logic [7:0] body[$];
        logic [7:0] b;
        int         len;
        body.push_back(8'($urandom_range(0, 255)));
        repeat (n_samples) begin
            if ($urandom_range(1, 100) <= esc_pct) begin
                body.push_back(ESCAPE_BYTE);
                body.push_back(8'($urandom_range(0, 255)));
                body.push_back(8'($urandom_range(0, 255)));
            end
            else begin
                b = 8'($urandom_range(0, 255));
                if (b == ESCAPE_BYTE)
                    b = 8'h7f;
                body.push_back(b);
            end
        end
        repeat (surplus) body.push_back(8'($urandom_range(0, 255)));
        len = (cut > 0 && cut < body.size()) ? cut : body.size();
        payload.push_back(len[15:8]);
        payload.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
            payload.push_back(body[i]);
    endtask

    initial
    begin
        int kind;
        int len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;

        // zero length, shift only, cut on a plain byte, on an escape, on its
        // high byte and on its low byte
        payload = '{8'h00, 8'h00,
                    8'h00, 8'h01, 8'hF0,
                    8'h00, 8'h04, 8'hF0, 8'h01, 8'h7F, 8'hFF,
                    8'h00, 8'h02, 8'h0F, 8'h80,
                    8'h00, 8'h03, 8'h00, 8'h80, 8'hFF,
                    8'h00, 8'h04, 8'h00, 8'h80, 8'h7F, 8'h00};

        while (payload.size() < PAYLOAD_MIN) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                payload.push_back(8'h00);
                payload.push_back(8'h00);
            end
            else if (kind == 1) begin
                len = $urandom_range(1, 24);
                payload.push_back(8'h00);
                payload.push_back(len[7:0]);
                repeat (len)
                    payload.push_back($urandom_range(0, 1) ? ESCAPE_BYTE
                                                           : 8'($urandom_range(0, 255)));
            end
            else begin
                queue_chunk($urandom_range(1, 40), 25, 0, $urandom_range(1, 130));
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < payload.size(); i++) begin
            if (i % 64 == 0) begin
                if (i >= payload.size() * 17 / 20) begin
                    gap_mode = 0;
                    stall_mode = 0;
                end
                else begin
                    gap_mode = $urandom_range(0, 2);
                    stall_mode = $urandom_range(0, 2);
                end
            end
            if (gap_mode != 0 && $urandom_range(0, gap_mode == 1 ? 7 : 1) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= payload[i];
            do @(posedge clk); while (in_stall);
            @(negedge clk);
        end
        in_valid <= 1'b0;
        stall_mode = 0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Fed %0d payload bytes across zero-length and cut-short chunks",
            byte_count);
        $display("Checked %0d samples, %0d chunk errors, %0d full chunk ends",
            sample_count, error_count, chunk_end_count);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
